// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the tag set table.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define AST_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is high.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: hw/rtl/tst_pkg.sv
// Shared types and constants of the tag set table: op and status codes,
// sequencer states, port widths and the slot memory control group. No dependencies.
package tst_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int DEF_CAPACITY = 16;
   localparam int DEF_TAG_BITS = 16;

   // Fixed widths of the beat fields.
   localparam int REQ_OP_W    = 2;
   localparam int REQ_TAG_W   = 16;
   localparam int STATUS_W    = 3;
   localparam int RSP_SLOT_W  = 4;
   localparam int RSP_COUNT_W = 5;

   // Request operation codes; the fourth code is unused and rejected.
   typedef enum logic [REQ_OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STS_ADDED    = 3'd0,
      STS_ALREADY  = 3'd1,
      STS_FULL     = 3'd2,
      STS_REMOVED  = 3'd3,
      STS_NOTFOUND = 3'd4,
      STS_PRESENT  = 3'd5,
      STS_ABSENT   = 3'd6,
      STS_INVALID  = 3'd7
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   // Read and write enables of the slot memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

// File: hw/rtl/tst_store.sv
// Slot memory of the tag set table: one write port, one registered read port.
// Depends on tst_pkg for the memory control group.
module tst_store #(
   parameter int CAPACITY = 16,
   parameter int SLOT_W   = 16
) (
   input  logic                        clock,
   input  tst_pkg::ram_ctl_type        ram_ctl,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [SLOT_W-1:0]           wr_data,
   output logic [SLOT_W-1:0]           rd_data
);
   import tst_pkg::*;

   logic [SLOT_W-1:0] mem [CAPACITY];
   logic [SLOT_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ram_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tst_ctrl.sv
// Sequencer and shared comparator of the tag set table: scans the written
// slots one per cycle, then decides and writes back. Depends on tst_pkg.
module tst_ctrl #(
   parameter int CAPACITY = 16,
   parameter int SLOT_W   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tst_pkg::REQ_OP_W-1:0]      op,
   input  logic [tst_pkg::REQ_TAG_W-1:0]     tag,
   output tst_pkg::ram_ctl_type              ram_ctl,
   output logic [$clog2(CAPACITY)-1:0]       rd_addr,
   output logic [$clog2(CAPACITY)-1:0]       wr_addr,
   output logic [SLOT_W-1:0]                 wr_data,
   input  logic [SLOT_W-1:0]                 rd_data,
   output logic                              rsp_valid,
   output logic [tst_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tst_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic [tst_pkg::RSP_COUNT_W-1:0]   rsp_tag_count
);
   import tst_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [SLOT_W-1:0] tag_ff, tag_in;
   logic              bad_ff, bad_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [RSP_SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [SLOT_W-1:0] tag_m;
   logic              req_ok;
   logic              accept;
   logic              scan_issue;
   logic              hit_now;
   logic              free_now;
   logic              last_cmp;
   logic              scan_done;
   logic              ram_wr_en;
   status_type        status_d;
   logic [IW-1:0]     slot_d;
   logic [31:0]       slot_wide;
   logic [31:0]       count_wide;

   // Request decode: the tag is taken modulo the stored tag width.
   assign tag_m  = tag[SLOT_W-1:0];
   assign req_ok = (tag_m != '0) && (op inside {OP_ADD, OP_REMOVE, OP_QUERY});
   assign accept = start && (state_ff == S_IDLE);

   // Shared comparator on the slot just read back.
   assign scan_issue = (state_ff == S_SCAN) && (idx_ff < fill_ff) && !hit_ff;
   assign hit_now    = (state_ff == S_SCAN) && pend_ff && (rd_data == tag_ff);
   assign free_now   = (state_ff == S_SCAN) && pend_ff && (rd_data == '0);
   assign last_cmp   = pend_ff && ((CW'(cmp_idx_ff) + CW'(1)) == fill_ff);
   assign scan_done  = hit_now || last_cmp;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = (req_ok && (fill_ff != '0)) ? S_SCAN : S_DECIDE;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outcome of the operation once the scan is over.
   always_comb begin
      status_d = STS_INVALID;
      slot_d   = '0;
      wr_addr  = '0;
      wr_data  = '0;
      fill_in  = fill_ff;
      count_in = count_ff;
      ram_wr_en = 1'b0;
      if (!bad_ff) begin
         case (op_ff)
            OP_ADD: begin
               if (hit_ff) begin
                  status_d = STS_ALREADY;
                  slot_d   = hit_idx_ff;
               end else if (free_ff) begin
                  status_d = STS_ADDED;
                  slot_d   = free_idx_ff;
               end else if (fill_ff < CW'(CAPACITY)) begin
                  status_d = STS_ADDED;
                  slot_d   = fill_ff[IW-1:0];
               end else begin
                  status_d = STS_FULL;
               end
            end
            OP_REMOVE: begin
               status_d = hit_ff ? STS_REMOVED : STS_NOTFOUND;
               slot_d   = hit_ff ? hit_idx_ff : '0;
            end
            OP_QUERY: begin
               status_d = hit_ff ? STS_PRESENT : STS_ABSENT;
               slot_d   = hit_ff ? hit_idx_ff : '0;
            end
            default: begin
               status_d = STS_INVALID;
            end
         endcase
      end
      // The write-back and the counters move only in the decide cycle.
      if (state_ff == S_DECIDE) begin
         wr_addr = slot_d;
         if (status_d == STS_ADDED) begin
            ram_wr_en = 1'b1;
            wr_data  = tag_ff;
            count_in = count_ff + CW'(1);
            if (!free_ff) begin
               fill_in = fill_ff + CW'(1);
            end
         end else if (status_d == STS_REMOVED) begin
            ram_wr_en = 1'b1;
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   // Outputs of the sequencer: busy flag and the memory ports.
   always_comb begin
      busy          = (state_ff != S_IDLE);
      ram_ctl.rd_en = scan_issue;
      ram_ctl.wr_en = ram_wr_en;
      rd_addr       = idx_ff[IW-1:0];
   end

   // Scan bookkeeping and request capture.
   always_comb begin
      op_in       = op_ff;
      tag_in      = tag_ff;
      bad_in      = bad_ff;
      idx_in      = idx_ff;
      pend_in     = scan_issue;
      cmp_idx_in  = scan_issue ? idx_ff[IW-1:0] : cmp_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (accept) begin
         op_in   = op_type'(op);
         tag_in  = tag_m;
         bad_in  = !req_ok;
         idx_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (scan_issue) begin
            idx_in = idx_ff + CW'(1);
         end
         if (hit_now) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         // Only the lowest empty slot is kept.
         if (free_now && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   // Result beat, registered from the decide cycle.
   always_comb begin
      slot_wide     = 32'(slot_d);
      count_wide    = 32'(count_in);
      rsp_valid_in  = (state_ff == S_DECIDE);
      rsp_status_in = status_d;
      rsp_slot_in   = slot_wide[RSP_SLOT_W-1:0];
      rsp_count_in  = count_wide[RSP_COUNT_W-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         bad_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_tag_count = rsp_count_ff;

endmodule

// File: hw/rtl/tag_set_table.sv
// Top level of the tag set table: the sequencer and the slot memory.
// Depends on tst_pkg, tst_ctrl and tst_store.
//
// Usage. A request beat (req_op, req_tag) is taken at a rising edge where
// start is high and busy is low. Op 0 adds the tag, 1 removes it, 2 asks
// whether it is held; a zero tag or op 3 is answered as invalid at once.
// Exactly one result beat follows per request: rsp_valid is high for one
// cycle with rsp_status, rsp_slot and rsp_tag_count (tags held afterwards).
// The receiver cannot stall, so results are never held back or dropped.
// Scan. The sequencer reads the written slots, those below the fill mark,
// one per cycle through the single read port of the slot memory and checks
// each with one comparator; a match ends the scan early. An invalid request
// or an empty table skips the scan and goes straight to the decide step.
// busy falls in the cycle that shows the result, and a new request may be
// taken in that same cycle.
// Reset. A synchronous reset empties the table at once: fill mark and count
// return to zero, and slots at or above the fill mark read as empty, so no
// clearing pass is needed.
module tag_set_table #(
   parameter int CAPACITY = tst_pkg::DEF_CAPACITY,
   parameter int TAG_BITS = tst_pkg::DEF_TAG_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tst_pkg::REQ_OP_W-1:0]      req_op,
   input  logic [tst_pkg::REQ_TAG_W-1:0]     req_tag,
   output logic                              rsp_valid,
   output logic [tst_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tst_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic [tst_pkg::RSP_COUNT_W-1:0]   rsp_tag_count
);
   import tst_pkg::*;

   // Stored tag width: the beat carries at most REQ_TAG_W bits.
   localparam int SLOT_W = (TAG_BITS < REQ_TAG_W) ? TAG_BITS : REQ_TAG_W;
   localparam int IW     = $clog2(CAPACITY);

   ram_ctl_type       ram_ctl;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   logic [SLOT_W-1:0] wr_data;
   logic [SLOT_W-1:0] rd_data;

   // Sequencer with the shared comparator.
   tst_ctrl #(
      .CAPACITY (CAPACITY),
      .SLOT_W   (SLOT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .op            (req_op),
      .tag           (req_tag),
      .ram_ctl       (ram_ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_tag_count (rsp_tag_count)
   );

   // Slot memory.
   tst_store #(
      .CAPACITY (CAPACITY),
      .SLOT_W   (SLOT_W)
   ) u_store (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// File: hw/rtl/tst_checker.sv
// Port-level checks of the tag set table and the bind that attaches them.
// Depends on tst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [tst_pkg::STATUS_W-1:0]      rsp_status,
   input logic [tst_pkg::RSP_SLOT_W-1:0]    rsp_slot
);
   import tst_pkg::*;

   logic accept;
   logic no_slot_sts;

   assign accept      = start && !busy;
   assign no_slot_sts = (rsp_status == STS_INVALID) || (rsp_status == STS_FULL) ||
                        (rsp_status == STS_NOTFOUND) || (rsp_status == STS_ABSENT);

   // Every accepted request makes the block busy in the next cycle.
   `AST_NEXT(a_accept_busy, clock, reset, accept, busy)
   // The block goes idle only together with its result beat.
   `AST_IMPLY(a_idle_result, clock, reset, $fell(busy), rsp_valid)
   // Result beats are single cycles, one per request.
   `AST_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid)
   // Outcomes that touch no slot report slot zero.
   `AST_IMPLY(a_slot_zero, clock, reset, rsp_valid && no_slot_sts, rsp_slot == '0)

endmodule

bind tag_set_table tst_checker u_tst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_slot   (rsp_slot)
);

// File: bench/testbench.sv
// Self-checking bench for the tag set table: directed beats from a table, then random
// add, remove and query traffic checked against a behavioural copy of the slot table.
// Depends on tst_pkg and the tag_set_table top level.
module testbench;
   import tst_pkg::*;

   localparam int CAP        = DEF_CAPACITY;
   localparam int RUN_LIMIT  = 200000;
   localparam int SETTLE     = DEF_CAPACITY + 8;
   localparam int PHASE_LEN  = 433;
   localparam int POOL_SIZE  = 24;
   localparam int PRINT_CAP  = 40;
   localparam logic [REQ_OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [REQ_TAG_W-1:0]   tag_t;
   typedef logic [RSP_SLOT_W-1:0]  slot_t;
   typedef logic [RSP_COUNT_W-1:0] count_t;

   // One result beat as the table should give it.
   typedef struct packed {
      status_type status;
      slot_t      slot;
      count_t     count;
   } rsp_beat;

   // One row of the directed part; the expected beat is used only when fixed is set.
   typedef struct packed {
      logic [REQ_OP_W-1:0] op;
      tag_t                tag;
      logic                fixed;
      rsp_beat             want;
   } dir_row;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [REQ_OP_W-1:0]      req_op = OP_ADD;
   tag_t                     req_tag = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   slot_t                    rsp_slot;
   count_t                   rsp_tag_count;

   // Expectation travelling with the beat on the request ports.
   logic                     cur_fixed = 1'b0;
   rsp_beat                  cur_want = '0;

   // Behavioural copy of the table.
   tag_t                     held_tags [CAP];
   int                       fill_mark;
   int                       held_count;

   rsp_beat                  awaited_rsp [$];
   int                       error_count = 0;
   int                       accepted_beats = 0;
   int                       cycle_count = 0;
   int                       status_seen [8];
   dir_row                   dir_table [26];
   tag_t                     tag_pool [POOL_SIZE];

   tag_set_table i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_tag       (req_tag),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_tag_count (rsp_tag_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
                  cycle_count, what, got, want);
      end
   endtask

   // Applies one request to the copy of the table and returns the beat it gives.
   function automatic rsp_beat table_update(input logic [REQ_OP_W-1:0] op, input tag_t tag);
      rsp_beat res;
      int      hit;
      int      pos;
      res.status = STS_INVALID;
      res.slot   = '0;
      hit = CAP;
      pos = CAP;
      if (tag != '0 && op != OP_UNUSED) begin
         for (int i = 0; i < CAP; i++) begin
            if (hit == CAP && held_tags[i] == tag) hit = i;
         end
         case (op)
            OP_ADD: begin
               if (hit < CAP) begin
                  res.status = STS_ALREADY;
                  res.slot   = slot_t'(hit);
               end else begin
                  // Reuse the lowest hole below the fill mark before appending.
                  for (int i = 0; i < fill_mark; i++) begin
                     if (pos == CAP && held_tags[i] == '0) pos = i;
                  end
                  if (pos == CAP && fill_mark < CAP) begin
                     pos = fill_mark;
                     fill_mark++;
                  end
                  if (pos < CAP) begin
                     held_tags[pos] = tag;
                     held_count++;
                     res.status = STS_ADDED;
                     res.slot   = slot_t'(pos);
                  end else begin
                     res.status = STS_FULL;
                  end
               end
            end
            OP_REMOVE: begin
               if (hit < CAP) begin
                  held_tags[hit] = '0;
                  if (held_count > 0) held_count--;
                  res.status = STS_REMOVED;
                  res.slot   = slot_t'(hit);
               end else begin
                  res.status = STS_NOTFOUND;
               end
            end
            default: begin
               if (hit < CAP) begin
                  res.status = STS_PRESENT;
                  res.slot   = slot_t'(hit);
               end else begin
                  res.status = STS_ABSENT;
               end
            end
         endcase
      end
      res.count = count_t'(held_count);
      return res;
   endfunction

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("run stopped by the cycle limit with %0d beats outstanding",
                  awaited_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Checks result beats and predicts every accepted request beat.
   always @(posedge clock) begin : rsp_monitor
      rsp_beat want;
      rsp_beat predicted;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", rsp_status, 0);
            end else begin
               want = awaited_rsp.pop_front();
               status_seen[want.status]++;
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_tag_count !== want.count)
                  report_mismatch("tag count", rsp_tag_count, want.count);
            end
         end
         if (start && busy === 1'b0) begin
            predicted = table_update(req_op, req_tag);
            awaited_rsp.push_back(cur_fixed ? cur_want : predicted);
            accepted_beats++;
         end
      end
   end

   // Presents one request beat and holds it until the table takes it.
   task automatic send_beat(input logic [REQ_OP_W-1:0] op, input tag_t tag,
                            input logic fixed, input rsp_beat want);
      @(negedge clock);
      start     <= 1'b1;
      req_op    <= op;
      req_tag   <= tag;
      cur_fixed <= fixed;
      cur_want  <= want;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Keeps start low for the given number of cycles.
   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Holds start low until every outstanding result beat has come back.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [REQ_OP_W-1:0] op;
      tag_t                tag;
      int                  add_pct;
      int                  pick;
      int                  idle_pct [3];

      idle_pct = '{19, 61, 0};
      for (int i = 0; i < CAP; i++) held_tags[i] = '0;
      fill_mark  = 0;
      held_count = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;

      // Directed part: empty table, invalid beats, hole reuse, filling up to full.
      dir_table = '{
         '{OP_QUERY,  16'h0001, 1'b1, '{STS_ABSENT,   4'd0, 5'd0}},
         '{OP_ADD,    16'h0000, 1'b1, '{STS_INVALID,  4'd0, 5'd0}},
         '{OP_UNUSED, 16'h0005, 1'b1, '{STS_INVALID,  4'd0, 5'd0}},
         '{OP_ADD,    16'hFFFF, 1'b1, '{STS_ADDED,    4'd0, 5'd1}},
         '{OP_ADD,    16'hFFFF, 1'b1, '{STS_ALREADY,  4'd0, 5'd1}},
         '{OP_ADD,    16'h0001, 1'b1, '{STS_ADDED,    4'd1, 5'd2}},
         '{OP_REMOVE, 16'hFFFF, 1'b1, '{STS_REMOVED,  4'd0, 5'd1}},
         '{OP_REMOVE, 16'hFFFF, 1'b1, '{STS_NOTFOUND, 4'd0, 5'd1}},
         '{OP_QUERY,  16'h0001, 1'b1, '{STS_PRESENT,  4'd1, 5'd1}},
         '{OP_ADD,    16'h0002, 1'b1, '{STS_ADDED,    4'd0, 5'd2}},
         '{OP_ADD,    16'h0004, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0008, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0010, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0020, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0040, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0080, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0100, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0200, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0400, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h0800, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h1000, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h2000, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h4000, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h8000, 1'b0, '{STS_ADDED,    4'd0, 5'd0}},
         '{OP_ADD,    16'h7777, 1'b1, '{STS_FULL,     4'd0, 5'd16}},
         '{OP_REMOVE, 16'h0000, 1'b1, '{STS_INVALID,  4'd0, 5'd16}}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_beat(dir_table[i].op, dir_table[i].tag, dir_table[i].fixed, dir_table[i].want);
      end
      drain_results();

      // Apart from zero tags, adds draw only from a small pool so that hits, holes and a full table all recur;
      // queries and removes also try arbitrary tags, which sweeps every tag bit.
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = tag_t'($urandom_range(1, 65535));

      for (int ph = 0; ph < 3; ph++) begin
         add_pct = 45;
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (n % 50 == 0) add_pct = $urandom_range(20, 70);
            pick = $urandom_range(99);
            if (pick < 4) op = OP_UNUSED;
            else if (pick < 4 + add_pct) op = OP_ADD;
            else if (pick < 4 + add_pct + (96 - add_pct) / 2) op = OP_REMOVE;
            else op = OP_QUERY;
            pick = $urandom_range(99);
            if (pick < 4) tag = '0;
            else if (pick < 80 || op == OP_ADD) tag = tag_pool[$urandom_range(POOL_SIZE - 1)];
            else tag = tag_t'($urandom_range(65535));
            if ($urandom_range(99) < idle_pct[ph]) idle_cycles($urandom_range(1, 6));
            send_beat(op, tag, 1'b0, '0);
         end
         drain_results();
      end

      // Let any late or stray beat show up before the verdict.
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d request beats: added %0d, already %0d, full %0d, removed %0d,",
               accepted_beats, status_seen[STS_ADDED], status_seen[STS_ALREADY],
               status_seen[STS_FULL], status_seen[STS_REMOVED]);
      $display("not found %0d, present %0d, absent %0d, invalid %0d; %0d mismatches",
               status_seen[STS_NOTFOUND], status_seen[STS_PRESENT], status_seen[STS_ABSENT],
               status_seen[STS_INVALID], error_count);
      if (error_count == 0 && awaited_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
